>>> sv/assert_macros.svh
// Assertion macros used by the thread slot manager top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/tsm_pkg.sv
// Types and codes shared by the thread slot manager modules.
package tsm_pkg;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_RESUME = 2'd1;
    localparam logic [1:0] OP_YIELD  = 2'd2;
    localparam logic [1:0] OP_DONE   = 2'd3;

    localparam logic [1:0] RC_OK            = 2'd0;
    localparam logic [1:0] RC_NO_ROUTINE    = 2'd1;
    localparam logic [1:0] RC_FULL          = 2'd2;
    localparam logic [1:0] RC_NOT_RESUMABLE = 2'd3;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_SUSPEND = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [5:0] slot_index;
        logic       has_routine;
    } tsm_req_t;

    typedef struct packed {
        logic [1:0] result_code;
        logic [5:0] slot_out;
        logic       current_valid;
        logic [5:0] current_slot;
        logic [6:0] unfinished_count;
        logic       all_done;
    } tsm_rsp_t;

    typedef struct packed {
        logic load;
        logic rd;
        logic exec;
        logic swap;
    } tsm_cmd_t;

    typedef struct packed {
        logic two_write;
    } tsm_sts_t;

endpackage

>>> sv/tsm_ctrl.sv
// Sequencer for one request: table read, execute, optional second status write.
module tsm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tsm_pkg::tsm_sts_t sts,
    output tsm_pkg::tsm_cmd_t cmd
);
    import tsm_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_SWAP = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.two_write ? S_SWAP : S_IDLE;
            end
            S_SWAP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign cmd.load = start && (state_reg == S_IDLE);
    assign cmd.rd   = (state_reg == S_READ);
    assign cmd.exec = (state_reg == S_EXEC);
    assign cmd.swap = (state_reg == S_SWAP);

endmodule

>>> sv/tsm_datapath.sv
// Slot tables, free list, current slot, counters and result register.
module tsm_datapath #(
    parameter int SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tsm_pkg::tsm_req_t request,
    input  tsm_pkg::tsm_cmd_t cmd,
    output tsm_pkg::tsm_sts_t sts,
    output tsm_pkg::tsm_rsp_t result,
    output logic              result_valid
);
    import tsm_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    // request latch
    logic [1:0] op_reg;
    logic [5:0] idx_reg;
    logic       hr_reg;

    // tables: status and free-list link {valid, slot}
    logic [1:0]  st_mem [SLOTS];
    logic [IW:0] ln_mem [SLOTS];
    logic [1:0]  st_rd_reg;
    logic [IW:0] ln_rd_reg;

    logic          fv_reg, fv_next;
    logic [IW-1:0] fh_reg, fh_next;
    logic          rv_reg, rv_next;
    logic [IW-1:0] rs_reg, rs_next;
    logic [IW-1:0] old_reg, old_next;
    logic [CW-1:0] used_reg, used_next;
    logic [CW-1:0] live_reg, live_next;

    tsm_rsp_t res_reg, res_next;
    logic     res_valid_reg, res_valid_next;

    logic [CW+5:0] idx_w;
    logic [IW-1:0] idx_addr;
    logic [IW-1:0] rd_addr;
    logic          idx_in_range;

    logic          st_we;
    logic [IW-1:0] st_wa;
    logic [1:0]    st_wd;
    logic          ln_we;
    logic [IW-1:0] ln_wa;
    logic [IW:0]   ln_wd;

    logic [1:0]    code;
    logic          alloc_ok;
    logic [IW-1:0] alloc_slot;
    logic          two_write;

    logic [IW+5:0] alloc_ext;
    logic [IW+5:0] run_ext;
    logic [CW+6:0] live_ext;

    assign idx_w        = {{CW{1'b0}}, idx_reg};
    assign idx_addr     = idx_w[IW-1:0];
    assign idx_in_range = (idx_w < {6'b0, used_reg});
    assign rd_addr      = (op_reg == OP_CREATE) ? fh_reg : idx_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= request.opcode;
            idx_reg <= request.slot_index;
            hr_reg  <= request.has_routine;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        if (ln_we)
        begin
            ln_mem[ln_wa] <= ln_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            st_rd_reg <= st_mem[rd_addr];
            ln_rd_reg <= ln_mem[rd_addr];
        end
    end

    always_comb
    begin
        fv_next    = fv_reg;
        fh_next    = fh_reg;
        rv_next    = rv_reg;
        rs_next    = rs_reg;
        old_next   = old_reg;
        used_next  = used_reg;
        live_next  = live_reg;
        code       = RC_OK;
        alloc_ok   = 1'b0;
        alloc_slot = fh_reg;
        two_write  = 1'b0;
        st_we      = 1'b0;
        st_wa      = rs_reg;
        st_wd      = ST_SUSPEND;
        ln_we      = 1'b0;
        ln_wa      = rs_reg;
        ln_wd      = {fv_reg, fh_reg};

        if (cmd.exec)
        begin
            unique case (op_reg)
                OP_CREATE:
                begin
                    if (!hr_reg)
                    begin
                        code = RC_NO_ROUTINE;
                    end
                    else if (fv_reg)
                    begin
                        alloc_ok   = 1'b1;
                        alloc_slot = fh_reg;
                        fv_next    = ln_rd_reg[IW];
                        fh_next    = ln_rd_reg[IW-1:0];
                    end
                    else if (used_reg < CW'(SLOTS))
                    begin
                        alloc_ok   = 1'b1;
                        alloc_slot = used_reg[IW-1:0];
                        used_next  = used_reg + CW'(1);
                    end
                    else
                    begin
                        code = RC_FULL;
                    end
                    if (alloc_ok)
                    begin
                        st_we     = 1'b1;
                        st_wa     = alloc_slot;
                        st_wd     = ST_SUSPEND;
                        ln_we     = 1'b1;
                        ln_wa     = alloc_slot;
                        ln_wd     = '0;
                        live_next = live_reg + CW'(1);
                    end
                end
                OP_RESUME:
                begin
                    if (!idx_in_range || (st_rd_reg != ST_SUSPEND))
                    begin
                        code = RC_NOT_RESUMABLE;
                    end
                    else
                    begin
                        st_we     = 1'b1;
                        st_wa     = idx_addr;
                        st_wd     = ST_RUNNING;
                        // previous thread gets suspended on the next cycle
                        two_write = rv_reg;
                        old_next  = rs_reg;
                        rv_next   = 1'b1;
                        rs_next   = idx_addr;
                    end
                end
                OP_YIELD:
                begin
                    st_we   = rv_reg;
                    st_wa   = rs_reg;
                    st_wd   = ST_SUSPEND;
                    rv_next = 1'b0;
                    rs_next = '0;
                end
                OP_DONE:
                begin
                    if (rv_reg)
                    begin
                        st_we   = 1'b1;
                        st_wa   = rs_reg;
                        st_wd   = ST_DONE;
                        ln_we   = 1'b1;
                        ln_wa   = rs_reg;
                        ln_wd   = {fv_reg, fh_reg};
                        fv_next = 1'b1;
                        fh_next = rs_reg;
                        if (live_reg != '0)
                        begin
                            live_next = live_reg - CW'(1);
                        end
                        rv_next = 1'b0;
                        rs_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.swap)
        begin
            st_we = 1'b1;
            st_wa = old_reg;
            st_wd = ST_SUSPEND;
        end
    end

    assign alloc_ext = {6'b0, alloc_slot};
    assign run_ext   = {6'b0, rs_next};
    assign live_ext  = {7'b0, live_next};

    always_comb
    begin
        res_next                  = res_reg;
        res_next.result_code      = code;
        res_next.slot_out         = alloc_ok ? alloc_ext[5:0] : 6'd0;
        res_next.current_valid    = rv_next;
        res_next.current_slot     = rv_next ? run_ext[5:0] : 6'd0;
        res_next.unfinished_count = live_ext[6:0];
        res_next.all_done         = (live_next == '0);
    end

    assign res_valid_next = (cmd.exec && !two_write) || cmd.swap;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_reg <= res_next;
            old_reg <= old_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg        <= 1'b0;
            fh_reg        <= '0;
            rv_reg        <= 1'b0;
            rs_reg        <= '0;
            used_reg      <= '0;
            live_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fv_reg        <= fv_next;
            fh_reg        <= fh_next;
            rv_reg        <= rv_next;
            rs_reg        <= rs_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign sts.two_write = two_write;
    assign result        = res_reg;
    assign result_valid  = res_valid_reg;

endmodule

>>> sv/thread_slot_manager.sv
// Top level of the thread slot manager: sequencer plus slot datapath.
//
//  channel   ports                          word        handshake
//  request   start, busy, request           tsm_req_t   taken when start && !busy
//  result    result_valid, result           tsm_rsp_t   one-cycle strobe, no backpressure
//
// A result word is registered in the execute state and shown once back in idle;
// a resume that displaces a running thread shows it after the swap state's extra write.
// The single-port status/link tables (read, then write) allow one request in flight.
// busy drops in the cycle the result is shown, so a new request may be taken then.
// Reset clears the free list, current slot and counters; the tables need no clear.
// The receiver cannot stall: each result is valid for exactly one cycle.
module thread_slot_manager #(
    parameter int SLOTS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tsm_pkg::tsm_req_t request,
    output logic              result_valid,
    output tsm_pkg::tsm_rsp_t result
);
    import tsm_pkg::*;

    `include "assert_macros.svh"

    tsm_cmd_t cmd;
    tsm_sts_t sts;

    tsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    tsm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy && !result_valid, "accept must raise busy")
    `ASSERT_NEXT(a_single_strobe, result_valid, !result_valid, "result strobe longer than one cycle")
    `ASSERT_NOW(a_fail_no_slot, result_valid && (result.result_code != RC_OK), result.slot_out == 6'd0, "failed request reports a slot")
    `ASSERT_NOW(a_swap_after_exec, cmd.swap, !busy == 1'b0, "second write outside a request")

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for thread_slot_manager: a directed request table, then random phases, all checked.
module tb;
    import tsm_pkg::*;

    localparam int NSLOTS       = 64;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_ITEMS   = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        tsm_req_t req;
        logic     exact;
        tsm_rsp_t rsp;
    } step_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     result_valid;
    tsm_req_t request;
    tsm_rsp_t result;

    // shadow of the slot table
    logic [1:0] slot_state   [NSLOTS];
    int         free_next    [NSLOTS];
    logic       free_next_ok [NSLOTS];
    logic       head_ok;
    int         head_slot;
    logic       run_ok;
    int         run_slot;
    int         appended;
    int         live;

    tsm_rsp_t   pending_rsp [$];
    step_row_t  step_rows [$];
    int         errors;
    int         quiet_cycles;
    logic       took_word;
    logic       word_seen;

    thread_slot_manager #(.SLOTS(NSLOTS)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tsm_req_t mk_req(logic [1:0] op, logic [5:0] idx, logic hr);
        tsm_req_t req;
        req.opcode      = op;
        req.slot_index  = idx;
        req.has_routine = hr;
        return req;
    endfunction

    function automatic tsm_rsp_t mk_rsp(logic [1:0] rc, logic [5:0] slot, logic cv,
                                        logic [5:0] cs, logic [6:0] cnt, logic ad);
        tsm_rsp_t rsp;
        rsp.result_code      = rc;
        rsp.slot_out         = slot;
        rsp.current_valid    = cv;
        rsp.current_slot     = cs;
        rsp.unfinished_count = cnt;
        rsp.all_done         = ad;
        return rsp;
    endfunction

    function automatic tsm_rsp_t predict_word(tsm_req_t req);
        tsm_rsp_t rsp;
        int       s;
        int       idx;
        rsp = '0;
        s   = 0;
        idx = int'(req.slot_index);
        case (req.opcode)
            OP_CREATE:
            begin
                if (!req.has_routine)
                    rsp.result_code = RC_NO_ROUTINE;
                else if (head_ok)
                begin
                    // LIFO reuse of the last finished slot
                    s         = head_slot;
                    head_ok   = free_next_ok[s];
                    head_slot = free_next[s];
                end
                else if (appended < NSLOTS)
                begin
                    s = appended;
                    appended++;
                end
                else
                    rsp.result_code = RC_FULL;
                if (rsp.result_code == RC_OK)
                begin
                    free_next_ok[s] = 1'b0;
                    free_next[s]    = 0;
                    slot_state[s]   = ST_SUSPEND;
                    live++;
                    rsp.slot_out = 6'(s);
                end
            end
            OP_RESUME:
            begin
                if (idx >= appended || slot_state[idx] != ST_SUSPEND)
                    rsp.result_code = RC_NOT_RESUMABLE;
                else
                begin
                    if (run_ok)
                        slot_state[run_slot] = ST_SUSPEND;
                    slot_state[idx] = ST_RUNNING;
                    run_ok   = 1'b1;
                    run_slot = idx;
                end
            end
            OP_YIELD:
            begin
                if (run_ok)
                    slot_state[run_slot] = ST_SUSPEND;
                run_ok   = 1'b0;
                run_slot = 0;
            end
            default:
            begin
                if (run_ok)
                begin
                    s = run_slot;
                    free_next_ok[s] = head_ok;
                    free_next[s]    = head_slot;
                    slot_state[s]   = ST_DONE;
                    head_ok   = 1'b1;
                    head_slot = s;
                    if (live > 0)
                        live--;
                    run_ok   = 1'b0;
                    run_slot = 0;
                end
            end
        endcase
        rsp.current_valid    = run_ok;
        rsp.current_slot     = run_ok ? 6'(run_slot) : 6'd0;
        rsp.unfinished_count = 7'(live);
        rsp.all_done         = (live == 0);
        return rsp;
    endfunction

    // mix weights in percent; the rest goes to done
    function automatic tsm_req_t random_word(int create_w, int resume_w, int yield_w);
        tsm_req_t req;
        int       roll;
        int       parked [$];
        req.slot_index  = 6'($urandom_range(63));
        req.has_routine = 1'($urandom_range(1));
        roll = int'($urandom_range(99));
        if (roll < create_w)
        begin
            req.opcode      = OP_CREATE;
            req.has_routine = ($urandom_range(15) != 0);
        end
        else if (roll < create_w + resume_w)
        begin
            req.opcode = OP_RESUME;
            for (int i = 0; i < appended; i++)
                if (slot_state[i] == ST_SUSPEND)
                    parked = {parked, i};
            if (parked.size() > 0 && $urandom_range(3) != 0)
                req.slot_index = 6'(parked[$urandom_range(parked.size() - 1)]);
        end
        else if (roll < create_w + resume_w + yield_w)
            req.opcode = OP_YIELD;
        else
            req.opcode = OP_DONE;
        return req;
    endfunction

    task automatic add_row(tsm_req_t req, logic exact, tsm_rsp_t rsp);
        step_row_t row;
        row.req   = req;
        row.exact = exact;
        row.rsp   = rsp;
        step_rows = {step_rows, row};
    endtask

    // entered and left at a falling edge
    task automatic send_word(tsm_req_t req, logic exact, tsm_rsp_t typed, int idle_pct);
        tsm_rsp_t want;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        took_word = 1'b1;
        want = predict_word(req);
        pending_rsp = {pending_rsp, (exact ? typed : want)};
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rsp.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        tsm_rsp_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            word_seen = 1'b1;
            if (pending_rsp.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, result);
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("result_code", 7'(want.result_code), 7'(result.result_code));
                check_field("slot_out", 7'(want.slot_out), 7'(result.slot_out));
                check_field("current_valid", 7'(want.current_valid), 7'(result.current_valid));
                check_field("current_slot", 7'(want.current_slot), 7'(result.current_slot));
                check_field("unfinished_count", want.unfinished_count,
                            result.unfinished_count);
                check_field("all_done", 7'(want.all_done), 7'(result.all_done));
            end
        end
    end

    always @(negedge clk)
    begin
        if (took_word || word_seen)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        took_word = 1'b0;
        word_seen = 1'b0;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        int       idle_pct [4];
        int       create_w [4];
        int       resume_w [4];
        int       yield_w  [4];
        tsm_rsp_t none;

        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        errors       = 0;
        quiet_cycles = 0;
        took_word    = 1'b0;
        word_seen    = 1'b0;
        none         = '0;
        head_ok      = 1'b0;
        head_slot    = 0;
        run_ok       = 1'b0;
        run_slot     = 0;
        appended     = 0;
        live         = 0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_state[i]   = ST_RUNNING;
            free_next[i]    = 0;
            free_next_ok[i] = 1'b0;
        end

        // idle table: nothing runs, no threads
        add_row(mk_req(OP_YIELD, 6'd0, 1'b0), 1'b1,
                mk_rsp(RC_OK, 6'd0, 1'b0, 6'd0, 7'd0, 1'b1));
        add_row(mk_req(OP_DONE, 6'd63, 1'b1), 1'b1,
                mk_rsp(RC_OK, 6'd0, 1'b0, 6'd0, 7'd0, 1'b1));
        add_row(mk_req(OP_RESUME, 6'd63, 1'b1), 1'b1,
                mk_rsp(RC_NOT_RESUMABLE, 6'd0, 1'b0, 6'd0, 7'd0, 1'b1));
        add_row(mk_req(OP_CREATE, 6'd63, 1'b0), 1'b1,
                mk_rsp(RC_NO_ROUTINE, 6'd0, 1'b0, 6'd0, 7'd0, 1'b1));
        add_row(mk_req(OP_CREATE, 6'd0, 1'b1), 1'b1,
                mk_rsp(RC_OK, 6'd0, 1'b0, 6'd0, 7'd1, 1'b0));
        add_row(mk_req(OP_CREATE, 6'd63, 1'b1), 1'b1,
                mk_rsp(RC_OK, 6'd1, 1'b0, 6'd0, 7'd2, 1'b0));
        // one past the appended slots
        add_row(mk_req(OP_RESUME, 6'd2, 1'b0), 1'b1,
                mk_rsp(RC_NOT_RESUMABLE, 6'd0, 1'b0, 6'd0, 7'd2, 1'b0));
        add_row(mk_req(OP_RESUME, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_RESUME, 6'd0, 1'b1), 1'b0, none);
        add_row(mk_req(OP_RESUME, 6'd1, 1'b0), 1'b0, none);   // displaces slot 0
        add_row(mk_req(OP_YIELD, 6'd63, 1'b1), 1'b0, none);
        add_row(mk_req(OP_YIELD, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_RESUME, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_DONE, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_RESUME, 6'd0, 1'b0), 1'b0, none);   // finished slot
        add_row(mk_req(OP_DONE, 6'd0, 1'b1), 1'b0, none);
        add_row(mk_req(OP_CREATE, 6'd5, 1'b1), 1'b0, none);   // reuses slot 0
        add_row(mk_req(OP_RESUME, 6'd1, 1'b0), 1'b0, none);
        add_row(mk_req(OP_DONE, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_RESUME, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_DONE, 6'd0, 1'b0), 1'b0, none);
        add_row(mk_req(OP_CREATE, 6'd0, 1'b1), 1'b0, none);   // free list: 0 then 1
        add_row(mk_req(OP_CREATE, 6'd0, 1'b1), 1'b0, none);
        add_row(mk_req(OP_CREATE, 6'd0, 1'b1), 1'b0, none);   // appends slot 2
        add_row(mk_req(OP_RESUME, 6'd2, 1'b1), 1'b0, none);

        // balanced, create-heavy to fill the table, drain, balanced
        idle_pct = '{0, 64, 0, 13};
        create_w = '{30, 65, 10, 30};
        resume_w = '{35, 20, 45, 35};
        yield_w  = '{10, 5, 5, 10};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (step_rows[i])
            send_word(step_rows[i].req, step_rows[i].exact, step_rows[i].rsp, 0);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            repeat (RAND_ITEMS / 4)
                send_word(random_word(create_w[p], resume_w[p], yield_w[p]), 1'b0, none,
                          idle_pct[p]);
            wait_idle();
        end

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/tsm_pkg.sv
sv/tsm_ctrl.sv
sv/tsm_datapath.sv
sv/thread_slot_manager.sv
tb/sv/tb.sv
